>>> src/lrs_pkg.sv
// package for the lsd radix sort block: constants and transaction structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package lrs_pkg;
   localparam int MaxKeysDefault   = 4096;
   localparam int DigitBitsDefault = 8;
   localparam int KeyWidth         = 64;

   localparam logic OpLoad  = 1'b0;
   localparam logic OpFetch = 1'b1;

   typedef struct packed {
      logic                operation;
      logic [KeyWidth-1:0] key;
      logic                last;
   } req_type;

   typedef struct packed {
      logic [KeyWidth-1:0] sorted_key;
      logic                is_final;
      logic                overflowed;
   } rsp_type;

   // datapath commands from the controller
   typedef enum logic [3:0] {
      CmdNone,
      CmdLoad,
      CmdFetch,
      CmdPassInit,
      CmdClear,
      CmdHist,
      CmdScan,
      CmdScatter,
      CmdPassEnd,
      CmdSortInit
   } cmd_code_type;

   typedef struct packed {
      cmd_code_type code;
   } cmd_type;

   typedef struct packed {
      logic sorted;       // a sorted set is available
      logic sweep_done;   // current sweep reached its end
      logic no_pass;      // the set needs no more passes
      logic skip_pass;    // only one digit value in this pass
   } stat_type;
endpackage
`default_nettype wire

>>> src/lrs_ctrl.sv
// controller state machine for the lsd radix sort
// depends on lrs_pkg
`timescale 1ns / 1ps
`default_nettype none
module lrs_ctrl (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   input  lrs_pkg::req_type  req_data,
   input  lrs_pkg::stat_type stat,
   output logic              busy,
   output lrs_pkg::cmd_type  cmd
);
   typedef enum logic [3:0] {
      StIdle, StInit, StPass, StClear, StHist, StScan, StDecide, StScatter, StEnd
   } state_type;

   state_type state_ff, state_in;
   logic      busy_in;

   always_comb begin
      state_in = state_ff;
      cmd.code = lrs_pkg::CmdNone;
      case (state_ff)
         StIdle: begin
            if (start) begin
               if (req_data.operation == lrs_pkg::OpLoad) begin
                  cmd.code = lrs_pkg::CmdLoad;
                  if (req_data.last) state_in = StInit;
               end else begin
                  cmd.code = lrs_pkg::CmdFetch;
               end
            end
         end
         StInit: begin
            cmd.code = lrs_pkg::CmdSortInit;
            state_in = StPass;
         end
         StPass: begin
            if (stat.no_pass) begin
               state_in = StIdle;
            end else begin
               cmd.code = lrs_pkg::CmdPassInit;
               state_in = StClear;
            end
         end
         StClear: begin
            cmd.code = lrs_pkg::CmdClear;
            if (stat.sweep_done) state_in = StHist;
         end
         StHist: begin
            cmd.code = lrs_pkg::CmdHist;
            if (stat.sweep_done) state_in = StScan;
         end
         StScan: begin
            cmd.code = lrs_pkg::CmdScan;
            if (stat.sweep_done) state_in = StDecide;
         end
         StDecide: begin
            state_in = stat.skip_pass ? StEnd : StScatter;
         end
         StScatter: begin
            cmd.code = lrs_pkg::CmdScatter;
            if (stat.sweep_done) state_in = StEnd;
         end
         StEnd: begin
            cmd.code = lrs_pkg::CmdPassEnd;
            state_in = StPass;
         end
         default: state_in = StIdle;
      endcase
      busy_in = (state_in != StIdle);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         busy     <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy     <= busy_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != StIdle) |-> busy)
      else $error("busy low while sorting");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == StDecide) |=> (state_ff == StScatter || state_ff == StEnd))
      else $error("bad exit from decide");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == StEnd) |=> (state_ff == StPass))
      else $error("pass end not followed by pass check");
endmodule
`default_nettype wire

>>> src/lrs_datapath.sv
// datapath for the lsd radix sort: key stores, histogram memory, counters
// depends on lrs_pkg
`timescale 1ns / 1ps
`default_nettype none
module lrs_datapath #(
   parameter int MAX_KEYS   = lrs_pkg::MaxKeysDefault,
   parameter int DIGIT_BITS = lrs_pkg::DigitBitsDefault
) (
   input  wire               clock,
   input  wire               reset,
   input  lrs_pkg::req_type  req_data,
   input  lrs_pkg::cmd_type  cmd,
   output lrs_pkg::stat_type stat,
   output logic              rsp_valid,
   output lrs_pkg::rsp_type  rsp_data
);
   localparam int KW      = lrs_pkg::KeyWidth;
   localparam int AW      = $clog2(MAX_KEYS);
   localparam int CW      = $clog2(MAX_KEYS + 1);
   localparam int RADIX   = 1 << DIGIT_BITS;
   localparam int PASSES  = (KW + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int PW      = $clog2(PASSES + 1);
   localparam int SW      = $clog2(KW);
   // sweep index covers the key count plus pipeline tail and the radix
   localparam int IW      = ((CW > DIGIT_BITS) ? CW : DIGIT_BITS) + 1;
   // offsets may exceed MAX_KEYS only by ending count, CW suffices
   localparam logic [CW-1:0] MaxCount = CW'(MAX_KEYS);

   logic [KW-1:0] store_a [MAX_KEYS];
   logic [KW-1:0] store_b [MAX_KEYS];
   logic [CW-1:0] offs    [RADIX];

   logic [CW-1:0]       count_ff;
   logic [KW-1:0]       largest_ff;
   logic                drop_ff;
   logic                sorted_ff;
   logic                src_ff;
   logic [CW-1:0]       rdptr_ff;
   logic [PW-1:0]       pass_ff;
   logic [PW-1:0]       npass_ff;
   logic [SW-1:0]       shift_ff;
   logic [IW-1:0]       idx_ff;      // sweep index, extra range for pipeline tail
   logic [CW-1:0]       cursor_ff;
   logic [DIGIT_BITS:0] populated_ff;
   logic                rd_valid_ff;
   logic [KW-1:0]       rd_key_a_ff, rd_key_b_ff;
   logic [DIGIT_BITS-1:0] rd_digit_ff;
   logic                dig_valid_ff;
   logic [KW-1:0]       dig_key_ff;
   logic [CW-1:0]       off_rd_ff;
   logic                off_valid_ff;
   logic [DIGIT_BITS-1:0] hist_digit_ff;
   logic                hist_valid_ff;
   logic [KW-1:0]       sc_key_ff;
   logic                fetch_ff;
   logic                rsp_final_ff;

   // passes needed: index of the highest nonzero digit plus one
   function automatic logic [PW-1:0] digits_needed(input logic [KW-1:0] v);
      logic [PW-1:0] n;
      n = '0;
      for (int p = 0; p < PASSES; p++)
         if ((v >> (p * DIGIT_BITS)) != '0) n = PW'(p + 1);
      return n;
   endfunction

   logic [KW-1:0] src_key;
   logic [DIGIT_BITS-1:0] src_digit;
   assign src_key   = src_ff ? rd_key_b_ff : rd_key_a_ff;
   assign src_digit = DIGIT_BITS'(src_key >> shift_ff);

   logic load_new;
   assign load_new = (cmd.code == lrs_pkg::CmdLoad) && sorted_ff;

   logic [CW-1:0] eff_count;
   assign eff_count = load_new ? '0 : count_ff;

   // sweep lengths with read pipeline latency
   logic sweep_last;
   always_comb begin
      case (cmd.code)
         lrs_pkg::CmdClear: sweep_last = (idx_ff == IW'(RADIX - 1));
         lrs_pkg::CmdScan:  sweep_last = (idx_ff == IW'(RADIX));
         lrs_pkg::CmdHist:  sweep_last = (idx_ff == IW'(count_ff) + IW'(2));
         lrs_pkg::CmdScatter: sweep_last = (idx_ff == IW'(count_ff) + IW'(2));
         default:           sweep_last = 1'b0;
      endcase
   end

   assign stat.sorted     = sorted_ff;
   assign stat.sweep_done = sweep_last;
   assign stat.no_pass    = (pass_ff >= npass_ff);
   assign stat.skip_pass  = (populated_ff == (DIGIT_BITS+1)'(1));

   logic [AW-1:0] rd_addr;
   assign rd_addr = (cmd.code == lrs_pkg::CmdFetch) ? rdptr_ff[AW-1:0] : idx_ff[AW-1:0];
   logic rd_in_range;
   assign rd_in_range = (idx_ff < IW'(count_ff));

   // key store memories: one write, one registered read each
   always_ff @(posedge clock) begin
      rd_key_a_ff <= store_a[rd_addr];
      rd_key_b_ff <= store_b[rd_addr];
      if (cmd.code == lrs_pkg::CmdLoad && eff_count < MaxCount)
         store_a[eff_count[AW-1:0]] <= req_data.key;
      if (cmd.code == lrs_pkg::CmdScatter && off_valid_ff && off_rd_ff < MaxCount) begin
         if (src_ff) store_a[off_rd_ff[AW-1:0]] <= sc_key_ff;
         else        store_b[off_rd_ff[AW-1:0]] <= sc_key_ff;
      end
   end

   // histogram memory: read registered, written one address a cycle
   logic [DIGIT_BITS-1:0] off_addr;
   logic                  off_we;
   logic [DIGIT_BITS-1:0] off_waddr;
   logic [CW-1:0]         off_wdata;
   always_comb begin
      off_addr  = rd_digit_ff;
      off_we    = 1'b0;
      off_waddr = hist_digit_ff;
      off_wdata = off_rd_ff + CW'(1);
      case (cmd.code)
         lrs_pkg::CmdClear: begin
            off_we    = 1'b1;
            off_waddr = idx_ff[DIGIT_BITS-1:0];
            off_wdata = '0;
         end
         lrs_pkg::CmdScan: begin
            off_addr  = idx_ff[DIGIT_BITS-1:0];
            off_we    = off_valid_ff;
            off_waddr = hist_digit_ff;
            off_wdata = cursor_ff;
         end
         lrs_pkg::CmdHist, lrs_pkg::CmdScatter: begin
            // forward back-to-back hits on the same digit
            off_we = off_valid_ff;
         end
         default: ;
      endcase
   end

   logic [CW-1:0] off_fwd;
   always_ff @(posedge clock) begin
      if (off_we) offs[off_waddr] <= off_wdata;
      off_rd_ff <= offs[off_addr];
      if (off_we && off_waddr == off_addr) off_rd_ff <= off_wdata;
   end
   assign off_fwd = off_rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         largest_ff   <= '0;
         drop_ff      <= 1'b0;
         sorted_ff    <= 1'b0;
         src_ff       <= 1'b0;
         rdptr_ff     <= '0;
         pass_ff      <= '0;
         npass_ff     <= '0;
         idx_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         dig_valid_ff <= 1'b0;
         off_valid_ff <= 1'b0;
         hist_valid_ff<= 1'b0;
         fetch_ff     <= 1'b0;
         rsp_valid    <= 1'b0;
      end else begin
         rsp_valid <= fetch_ff;
         fetch_ff  <= 1'b0;
         case (cmd.code)
            lrs_pkg::CmdLoad: begin
               if (load_new) begin
                  sorted_ff <= 1'b0;
                  rdptr_ff  <= '0;
                  src_ff    <= 1'b0;
               end
               if (eff_count < MaxCount) begin
                  count_ff <= eff_count + CW'(1);
                  if (load_new || req_data.key > largest_ff) largest_ff <= req_data.key;
                  if (load_new) drop_ff <= 1'b0;
               end else begin
                  drop_ff  <= 1'b1;
               end
            end
            lrs_pkg::CmdSortInit: begin
               src_ff    <= 1'b0;
               pass_ff   <= '0;
               npass_ff  <= digits_needed(largest_ff);
               sorted_ff <= 1'b1;
               rdptr_ff  <= '0;
            end
            lrs_pkg::CmdFetch: begin
               if (sorted_ff && rdptr_ff < count_ff) begin
                  fetch_ff     <= 1'b1;
                  rsp_final_ff <= (rdptr_ff + CW'(1) == count_ff);
                  rdptr_ff     <= rdptr_ff + CW'(1);
               end
            end
            lrs_pkg::CmdPassInit: begin
               shift_ff     <= SW'(pass_ff) * SW'(DIGIT_BITS);
               idx_ff       <= '0;
               cursor_ff    <= '0;
               populated_ff <= '0;
            end
            lrs_pkg::CmdClear, lrs_pkg::CmdHist, lrs_pkg::CmdScan,
            lrs_pkg::CmdScatter: begin
               idx_ff <= sweep_last ? '0 : idx_ff + IW'(1);
               rd_valid_ff   <= (cmd.code == lrs_pkg::CmdHist ||
                                 cmd.code == lrs_pkg::CmdScatter) && rd_in_range && !sweep_last;
               // stage 2: digit known, offset read issued
               dig_valid_ff  <= rd_valid_ff;
               dig_key_ff    <= src_key;
               // stage 3: offset data back, update written
               off_valid_ff  <= dig_valid_ff ||
                                (cmd.code == lrs_pkg::CmdScan && idx_ff < IW'(RADIX));
               hist_digit_ff <= (cmd.code == lrs_pkg::CmdScan) ?
                                idx_ff[DIGIT_BITS-1:0] : rd_digit_ff;
               sc_key_ff     <= dig_key_ff;
               if (cmd.code == lrs_pkg::CmdScan && off_valid_ff) begin
                  cursor_ff <= cursor_ff + off_fwd;
                  if (off_fwd != '0) populated_ff <= populated_ff + (DIGIT_BITS+1)'(1);
               end
               if (sweep_last) begin
                  rd_valid_ff  <= 1'b0;
                  dig_valid_ff <= 1'b0;
                  off_valid_ff <= 1'b0;
               end
            end
            lrs_pkg::CmdPassEnd: begin
               if (populated_ff != (DIGIT_BITS+1)'(1)) src_ff <= ~src_ff;
               pass_ff <= pass_ff + PW'(1);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rd_digit_ff <= src_digit;
   end

   logic [KW-1:0] fetch_key;
   assign fetch_key = src_ff ? rd_key_b_ff : rd_key_a_ff;
   logic [KW-1:0] rsp_key_ff;
   logic          rsp_ovf_ff;
   always_ff @(posedge clock) begin
      if (fetch_ff) begin
         rsp_key_ff <= fetch_key;
         rsp_ovf_ff <= drop_ff;
      end
   end
   // fetch read latency: address at cmd, data next cycle, register the cycle after
   assign rsp_data.sorted_key = rsp_key_ff;
   logic rsp_final_q;
   always_ff @(posedge clock) rsp_final_q <= rsp_final_ff;
   assign rsp_data.is_final   = rsp_final_q;
   assign rsp_data.overflowed = rsp_ovf_ff;

   assert property (@(posedge clock) disable iff (reset)
      fetch_ff |-> sorted_ff)
      else $error("response without a sorted set");
   assert property (@(posedge clock) disable iff (reset)
      (cmd.code == lrs_pkg::CmdLoad) |=> (count_ff != '0))
      else $error("load left count at zero");
   assert property (@(posedge clock) disable iff (reset)
      (count_ff <= MaxCount))
      else $error("count beyond capacity");
endmodule
`default_nettype wire

>>> src/lsd_radix_sort_u64.sv
// channel   ports                                  direction
// req       start, busy, req_data (lrs_pkg::req_type)   in, busy out
// rsp       rsp_valid, rsp_data (lrs_pkg::rsp_type)     out, one-cycle strobe
// a load or fetch is taken in the cycle start is high; busy holds off start only while a sort runs
// a sort runs a clear, histogram and scan sweep per pass, a skipped pass saving
// the scatter sweep, bound by the single read port on the key stores and offsets
// a fetch result strobes after passing fetch_ff and the response registers; reset is synchronous
// the receiver cannot stall results
// depends on lrs_pkg, lrs_ctrl, lrs_datapath
`timescale 1ns / 1ps
`default_nettype none
module lsd_radix_sort_u64 #(
   parameter int MAX_KEYS   = lrs_pkg::MaxKeysDefault,
   parameter int DIGIT_BITS = lrs_pkg::DigitBitsDefault
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              start,
   output logic             busy,
   input  lrs_pkg::req_type req_data,
   output logic             rsp_valid,
   output lrs_pkg::rsp_type rsp_data
);
   lrs_pkg::cmd_type  cmd;
   lrs_pkg::stat_type stat;
   lrs_pkg::req_type  req_gated;
   logic              go;

   assign go        = start && !busy;
   assign req_gated = req_data;

   lrs_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(go), .req_data(req_gated),
      .stat(stat), .busy(busy), .cmd(cmd)
   );

   lrs_datapath #(.MAX_KEYS(MAX_KEYS), .DIGIT_BITS(DIGIT_BITS)) u_dp (
      .clock(clock), .reset(reset), .req_data(req_gated), .cmd(cmd),
      .stat(stat), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );
endmodule
`default_nettype wire
